FILE: src/tscc_pkg.sv
// Shared types and constants of the transport stream continuity monitor.
`timescale 1ns / 1ps
`default_nettype none
package tscc_pkg;

  localparam int unsigned DefMaxTracks = 16;
  localparam logic [7:0]  PacketBytes  = 8'd188;
  localparam logic [7:0]  SyncByte     = 8'h47;
  localparam logic [12:0] NullPid      = 13'h1fff;

  typedef enum logic [2:0] {
    ST_UNTRACKED  = 3'd0,
    ST_SEEDED     = 3'd1,
    ST_CONTINUOUS = 3'd2,
    ST_DISCONT    = 3'd3,
    ST_SYNC_ERR   = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_CMP
  } ctrl_state_e;

  typedef struct packed {
    logic [12:0] pid;
    logic        seed_pending;
    logic [3:0]  prev_cc;
    logic [31:0] run;
  } track_t;

  typedef struct packed {
    logic accept;
    logic clr_idx;
    logic rd_en;
    logic inc_idx;
    logic resolve_found;
    logic resolve_new;
  } cmd_t;

  typedef struct packed {
    logic need_lookup;
    logic hit;
    logic at_end;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/tscc_byte_if.sv
// Byte input channel of the continuity monitor.
`timescale 1ns / 1ps
`default_nettype none
interface tscc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;
  modport source (output valid, data_byte, packet_start, input ready);
  modport sink   (input valid, data_byte, packet_start, output ready);
endinterface
`default_nettype wire

FILE: src/tscc_status_if.sv
// Status result channel of the continuity monitor.
`timescale 1ns / 1ps
`default_nettype none
interface tscc_status_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [12:0] packet_pid;
  logic [3:0]  cont_count;
  logic [31:0] run_count;
  modport source (output valid, status, packet_pid, cont_count, run_count, input ready);
  modport sink   (input valid, status, packet_pid, cont_count, run_count, output ready);
endinterface
`default_nettype wire

FILE: src/tscc_dp.sv
// Datapath: packet parser, PSI capture, track table and result register.
`timescale 1ns / 1ps
`default_nettype none
module tscc_dp import tscc_pkg::*; #(
  parameter int unsigned MAX_TRACKS = DefMaxTracks
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        packet_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [12:0]      packet_pid_o,
  output logic [3:0]       cont_count_o,
  output logic [31:0]      run_count_o
);

  localparam int unsigned IdxW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TRACKS + 1);

  logic [7:0]  bidx_q, bidx_d, poff_q, poff_d;
  logic [12:0] pid_q, pid_d, pmt_pid_q, pmt_pid_d, pcr_pid_q, pcr_pid_d;
  logic [3:0]  cc_q, cc_d;
  logic        skip_q, skip_d, pmt_known_q, pmt_known_d, pcr_known_q, pcr_known_d;
  logic [4:0]  phb_q, phb_d;
  logic [CntW-1:0] count_q, count_d, idx_q, idx_d;

  track_t mem [MAX_TRACKS];
  track_t rdata_q, wdata;
  logic   we;

  logic        ov_q, ov_d;
  status_e     ost_q, ost_d;
  logic [12:0] opid_q, opid_d;
  logic [3:0]  occ_q, occ_d;
  logic [31:0] orun_q, orun_d;

  logic       pos3, untracked;
  logic [8:0] sum9;
  logic [7:0] rel;

  assign untracked = (pid_q == 13'd0) || (pid_q == NullPid) || !pmt_known_q ||
                     !pcr_known_q || (pid_q == pmt_pid_q) || (pid_q == pcr_pid_q);
  assign pos3 = !packet_start_i && !skip_q && (bidx_q == 8'd3);
  assign sum9 = 9'd5 + {1'b0, data_byte_i};
  assign rel  = bidx_q - poff_q;

  assign sts_o.need_lookup = cmd_i.accept && pos3 && !untracked;
  assign sts_o.hit         = (rdata_q.pid == pid_q);
  assign sts_o.at_end      = (idx_q == count_q);
  assign sts_o.out_busy    = ov_q && !out_ready_i;

  always_comb begin
    bidx_d = bidx_q; poff_d = poff_q; pid_d = pid_q; cc_d = cc_q; skip_d = skip_q;
    phb_d = phb_q; pmt_pid_d = pmt_pid_q; pmt_known_d = pmt_known_q;
    pcr_pid_d = pcr_pid_q; pcr_known_d = pcr_known_q;
    count_d = count_q; idx_d = idx_q;
    ov_d = ov_q && !out_ready_i;
    ost_d = ost_q; opid_d = opid_q; occ_d = occ_q; orun_d = orun_q;
    we = 1'b0; wdata = rdata_q;

    if (cmd_i.accept) begin
      if (packet_start_i) begin
        skip_d = 1'b0; poff_d = 8'd0; bidx_d = 8'd1;
        if (data_byte_i != SyncByte) begin
          skip_d = 1'b1;
          ov_d = 1'b1; ost_d = ST_SYNC_ERR; opid_d = '0; occ_d = '0; orun_d = '0;
        end
      end else if (bidx_q != 8'd0 && bidx_q < PacketBytes && !skip_q) begin
        bidx_d = bidx_q + 8'd1;
        if (bidx_q == 8'd1) begin
          phb_d = data_byte_i[4:0];
        end else if (bidx_q == 8'd2) begin
          pid_d = {phb_q, data_byte_i};
        end else if (bidx_q == 8'd3) begin
          cc_d   = data_byte_i[3:0];
          poff_d = data_byte_i[5] ? 8'd0 : 8'd4;
          if (untracked) begin
            ov_d = 1'b1; ost_d = ST_UNTRACKED; opid_d = pid_q;
            occ_d = data_byte_i[3:0]; orun_d = '0;
          end
        end else if (poff_q == 8'd0) begin
          if (bidx_q == 8'd4) begin
            poff_d = sum9[8] ? 8'hff : sum9[7:0];
          end
        end else if (bidx_q >= poff_q) begin
          if (pmt_known_q && pid_q == pmt_pid_q) begin
            if (rel == 8'd9) begin
              phb_d = data_byte_i[4:0];
            end else if (rel == 8'd10) begin
              pcr_pid_d = {phb_q, data_byte_i}; pcr_known_d = 1'b1;
            end
          end
          if (pid_q == 13'd0) begin
            if (rel == 8'd11) begin
              phb_d = data_byte_i[4:0];
            end else if (rel == 8'd12) begin
              pmt_pid_d = {phb_q, data_byte_i}; pmt_known_d = 1'b1;
            end
          end
        end
      end
    end

    if (cmd_i.clr_idx) idx_d = '0;
    if (cmd_i.inc_idx) idx_d = idx_q + 1'b1;

    if (cmd_i.resolve_found) begin
      we = 1'b1; ov_d = 1'b1; opid_d = pid_q; occ_d = cc_q; orun_d = rdata_q.run;
      wdata = rdata_q;
      if (rdata_q.seed_pending) begin
        wdata.seed_pending = 1'b0; wdata.prev_cc = cc_q; ost_d = ST_SEEDED;
      end else if (rdata_q.prev_cc + 4'd1 == cc_q) begin
        wdata.prev_cc = cc_q; wdata.run = rdata_q.run + 32'd1; ost_d = ST_CONTINUOUS;
      end else begin
        wdata.seed_pending = 1'b1; wdata.prev_cc = '0; wdata.run = '0; ost_d = ST_DISCONT;
      end
    end

    if (cmd_i.resolve_new) begin
      ov_d = 1'b1; opid_d = pid_q; occ_d = cc_q; orun_d = '0;
      if (count_q == CntW'(MAX_TRACKS)) begin
        ost_d = ST_TABLE_FULL;
      end else begin
        ost_d = ST_SEEDED; we = 1'b1; count_d = count_q + 1'b1;
        wdata = '{pid: pid_q, seed_pending: 1'b0, prev_cc: cc_q, run: 32'd0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[idx_q[IdxW-1:0]] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[idx_q[IdxW-1:0]];
    ost_q <= ost_d; opid_q <= opid_d; occ_q <= occ_d; orun_q <= orun_d;
    pid_q <= pid_d; cc_q <= cc_d; phb_q <= phb_d; poff_q <= poff_d;
    pmt_pid_q <= pmt_pid_d; pcr_pid_q <= pcr_pid_d; idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidx_q <= '0; skip_q <= 1'b0; pmt_known_q <= 1'b0; pcr_known_q <= 1'b0;
      count_q <= '0; ov_q <= 1'b0;
    end else begin
      bidx_q <= bidx_d; skip_q <= skip_d; pmt_known_q <= pmt_known_d;
      pcr_known_q <= pcr_known_d; count_q <= count_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign status_o     = 3'(ost_q);
  assign packet_pid_o = opid_q;
  assign cont_count_o = occ_q;
  assign run_count_o  = orun_q;

endmodule
`default_nettype wire

FILE: src/tscc_ctrl.sv
// Controller: byte acceptance and track table search sequencing.
`timescale 1ns / 1ps
`default_nettype none
module tscc_ctrl import tscc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = !sts_i.out_busy;
        cmd_o.accept = in_valid_i && !sts_i.out_busy;
        if (sts_i.need_lookup) begin
          cmd_o.clr_idx = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.at_end) begin
          cmd_o.resolve_new = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.resolve_found = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d = S_LOOK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/ts_continuity_counter_monitor.sv
// Top level of the transport stream continuity counter monitor.
// A result for an untracked PID is registered in the cycle after the fourth
// byte of a packet, as is a sync error after its first byte; for a tracked PID
// it follows a table search that reads each entry through the table read port
// and then compares it. Throughput: one byte per cycle, except during that
// search or while a result waits for its transfer, when input stalls.
// Reset clears control state and the track count; table entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ts_continuity_counter_monitor import tscc_pkg::*; #(
  parameter int unsigned MAX_TRACKS = DefMaxTracks
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  tscc_byte_if.sink     in_i,
  tscc_status_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  tscc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tscc_dp #(.MAX_TRACKS(MAX_TRACKS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_byte_i    (in_i.data_byte),
    .packet_start_i (in_i.packet_start),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .status_o       (out_o.status),
    .packet_pid_o   (out_o.packet_pid),
    .cont_count_o   (out_o.cont_count),
    .run_count_o    (out_o.run_count)
  );

endmodule
`default_nettype wire
